// ----- rtl/core/ffra_pkg.sv -----
// Package for the first-fit region allocator: sizes, status codes, request codes.
// No dependencies.
package ffra_pkg;
  localparam int HEAP_BYTES_DEF    = 256;
  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOROOM   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;
endpackage

// ----- rtl/core/first_fit_region_allocator_core.sv -----
// First-fit region allocator. A request is taken when start is high and busy
// is low; busy stays high until the single result appears for one cycle with
// done high (the receiver cannot stall). Each table entry visited is read,
// then compared or written back, through the table RAM's separate read and
// write ports. A reallocate is a free followed, if its region is found, by an
// allocate.
// Depends on ffra_pkg and ffra_table_mem.
module first_fit_region_allocator_core import ffra_pkg::*; #(
  parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [$clog2(HEAP_BYTES):0]   alloc_size,
  input  logic [$clog2(HEAP_BYTES)-1:0] region_start,
  output logic                          done,
  output logic [$clog2(HEAP_BYTES)-1:0] granted_start,
  output logic [1:0]                    status
);
  localparam int SW = $clog2(HEAP_BYTES);
  localparam int LW = SW + 1;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] TE = CW'(TABLE_ENTRIES);
  localparam logic [LW:0] HB = (LW+1)'(HEAP_BYTES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FSCAN = 8'b00000010,  // free: search match
    S_FMOVE = 8'b00000100,  // free: compact down
    S_ASCAN = 8'b00001000,  // alloc: search gap
    S_AMOVE = 8'b00010000,  // alloc: shift up
    S_AWR   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_AWAIT = 8'b10000000
  } state_t;

  state_t state;
  logic [1:0] req;
  logic [LW-1:0] size;
  logic [SW-1:0] where;
  logic [CW-1:0] count, idx, pos;
  logic          rd_pend;
  logic [LW:0]   prev_end;
  logic [SW-1:0] ins_start;
  logic [1:0]    st;
  logic [SW-1:0] gnt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wstart, rstart;
  logic [LW-1:0] wlen, rlen;

  ffra_table_mem #(.AW(AW), .SW(SW), .LW(LW)) u_mem (
    .clk, .we, .waddr, .wstart, .wlen, .raddr, .rstart, .rlen
  );

  logic [LW:0] rd_end;
  assign rd_end = (LW+1)'(rstart) + (LW+1)'(rlen);
  assign busy = (state != S_IDLE);

  // Entry read issued at idx; data valid the next cycle (rd_pend).
  always_comb begin
    raddr  = idx[AW-1:0];
    we     = 1'b0;
    waddr  = idx[AW-1:0];
    wstart = rstart;
    wlen   = rlen;
    unique case (state)
      S_FMOVE: begin
        we    = rd_pend;
        waddr = AW'(idx - 1'b1);
      end
      S_AMOVE: begin
        we    = rd_pend;
        waddr = AW'(idx + 1'b1);
      end
      S_AWR: begin
        we     = 1'b1;
        waddr  = pos[AW-1:0];
        wstart = ins_start;
        wlen   = size;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          req   <= req_type;
          size  <= alloc_size;
          where <= region_start;
          st    <= ST_DONE;
          gnt   <= '0;
          idx   <= '0;
          priority if (req_type == REQ_FREE || req_type == REQ_REALLOC) begin
            state <= S_FSCAN;
          end else if (req_type == REQ_ALLOC) state <= S_AWAIT;
          else state <= S_OUT;
        end
        S_FSCAN: begin
          if (!rd_pend) begin
            if (idx >= count) begin
              st <= ST_NOTFOUND;
              state <= S_OUT;
            end else rd_pend <= 1'b1;
          end else if (rstart == where) begin
            count <= count - 1'b1;
            idx   <= idx + 1'b1;
            state <= S_FMOVE;
          end else idx <= idx + 1'b1;
        end
        S_FMOVE: begin
          // idx: entry to move down; count already decremented
          if (!rd_pend) begin
            if (idx > count) begin
              if (req == REQ_REALLOC) begin
                idx <= '0;
                state <= S_AWAIT;
              end else state <= S_OUT;
            end else rd_pend <= 1'b1;
          end else idx <= idx + 1'b1;
        end
        S_AWAIT: begin
          idx <= '0;
          prev_end <= '0;
          priority if (count >= TE) begin
            st <= ST_FULL;
            state <= S_OUT;
          end else if (count == '0) begin
            if ((LW+1)'(size) > HB) begin
              st <= ST_NOROOM;
              state <= S_OUT;
            end else begin
              ins_start <= '0;
              pos <= '0;
              state <= S_AWR;
            end
          end else state <= S_ASCAN;
        end
        S_ASCAN: begin
          // gap before entry idx: [prev_end, rstart)
          if (!rd_pend) begin
            if (idx >= count) begin
              if (prev_end + (LW+1)'(size) > HB) begin
                st <= ST_NOROOM;
                state <= S_OUT;
              end else begin
                ins_start <= prev_end[SW-1:0];
                gnt <= prev_end[SW-1:0];
                pos <= count;
                state <= S_AWR;
              end
            end else rd_pend <= 1'b1;
          end else if ((LW+1)'(rstart) >= prev_end &&
                       (LW+1)'(rstart) - prev_end >= (LW+1)'(size)) begin
            ins_start <= prev_end[SW-1:0];
            gnt <= prev_end[SW-1:0];
            pos <= idx;
            idx <= count - 1'b1;
            state <= S_AMOVE;
          end else begin
            prev_end <= rd_end;
            idx <= idx + 1'b1;
          end
        end
        S_AMOVE: begin
          // idx walks down from count-1 to pos, moving each entry up one
          if (!rd_pend) rd_pend <= 1'b1;
          else if (idx == pos) state <= S_AWR;
          else idx <= idx - 1'b1;
        end
        S_AWR: begin
          count <= count + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          granted_start <= (st == ST_DONE) ? gnt : '0;
          status <= st;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/ffra_table_mem.sv -----
// Region table storage: one synchronous RAM holding start and length per entry.
// Depends on ffra_pkg.
module ffra_table_mem import ffra_pkg::*; #(
  parameter int AW = 6,
  parameter int SW = 8,
  parameter int LW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [SW-1:0] wstart,
  input  logic [LW-1:0] wlen,
  input  logic [AW-1:0] raddr,
  output logic [SW-1:0] rstart,
  output logic [LW-1:0] rlen
);
  logic [SW+LW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wstart, wlen};
    {rstart, rlen} <= mem[raddr];
  end
endmodule
